/* rtl/core/phacc_pkg.sv */
// ----------------------------------------------------------------------------
// Persistence hit accumulator package
// Command codes and fixed field widths shared by the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package phacc_pkg;

  localparam int CMD_W    = 2;
  localparam int COL_W    = 8;
  localparam int LEVEL_W  = 10;
  localparam int SROW_W   = 8;
  localparam int HEAT_W   = 4;
  // Width used for range checks against the grid dimensions (up to 2047).
  localparam int CHECK_W  = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/persistence_hit_accumulator.sv */
// ----------------------------------------------------------------------------
// Persistence hit accumulator
// Grid of saturating hit counts for a persistence display, held in one
// synchronous memory and updated by read-modify-write with forwarding.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one command per transfer:
//   add a sample, read a cell for display, or clear the grid. Only a read
//   produces a transfer on the output channel (out_valid/out_ready), holding
//   the cell's heat level and a draw flag.
//   Read path: the memory is read at the edge of the input transfer, and
//   the read result is loaded into the output register, raising out_valid,
//   when the update stage advances.
//   Throughput: one add or read per cycle while in_ready is high; the memory
//   port pair (one read, one write per cycle) sets this, and forwarding
//   covers back-to-back hits on the same cell.
//   Clear: a clear command starts a sweep that writes zero to one entry per
//   cycle over all 2**(clog2(ROWS)+clog2(COLUMNS)) entries (65536 with the
//   default parameters); in_ready stays low during the sweep.
//   Reset: rst runs the same clearing sweep before the first transfer.
//   Stall: when a read result waits in the output register and out_ready is
//   low, a following read holds in the update stage and in_ready drops;
//   adds keep flowing until a read reaches the update stage.
// ----------------------------------------------------------------------------
`default_nettype none

module persistence_hit_accumulator
  import phacc_pkg::*;
#(
  parameter int COLUMNS = 256,
  parameter int ROWS    = 256,
  parameter int LEVELS  = 10
) (
  input  wire logic                      clk,
  input  wire logic                      rst,

  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [CMD_W-1:0]          cmd,
  input  wire logic [COL_W-1:0]          column,
  input  wire logic signed [LEVEL_W-1:0] sample_level,
  input  wire logic [SROW_W-1:0]         screen_row,

  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [HEAT_W-1:0]              heat_level,
  output logic                           draw_pixel
);

  // Memory geometry: the cell address is {level, column}.
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam int HW    = $clog2(LEVELS);

  localparam logic [HW-1:0] CELL_MAX = HW'(LEVELS - 1);

  // Hit count memory and its registered read port.
  logic [HW-1:0] hit_grid [DEPTH];
  logic [HW-1:0] rd_data;

  // Clearing sweep.
  logic          clearing;
  logic [AW-1:0] clear_pointer;

  // Decode of the offered item.
  cmd_t                 in_cmd;
  logic [CHECK_W-1:0]   col_ext;
  logic [CHECK_W-1:0]   lvl_ext;
  logic [CHECK_W-1:0]   srow_ext;
  logic [CHECK_W-1:0]   flip_ext;
  logic                 col_ok;
  logic                 lvl_ok;
  logic                 srow_ok;
  logic [AW-1:0]        rd_addr;
  logic                 rd_in_range;
  logic                 in_accept;

  // Update stage.
  logic                 s1_valid;
  logic                 s1_read;
  logic                 s1_in_range;
  logic [AW-1:0]        s1_addr;
  logic                 s1_advance;
  logic [HW-1:0]        s1_cell;
  logic [HW-1:0]        s1_cell_next;
  logic                 s1_write;

  // Forwarding of a write that lands on the edge of the following read.
  logic                 fwd_hit;
  logic [HW-1:0]        fwd_data;

  // Memory write port.
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [HW-1:0]        mem_wdata;

  assign in_cmd   = cmd_t'(cmd);
  assign col_ext  = CHECK_W'(column);
  assign lvl_ext  = CHECK_W'(unsigned'(sample_level));
  assign srow_ext = CHECK_W'(screen_row);
  assign flip_ext = CHECK_W'(ROWS - 1) - srow_ext;

  assign col_ok  = col_ext < CHECK_W'(COLUMNS);
  assign lvl_ok  = !sample_level[LEVEL_W-1] && (lvl_ext < CHECK_W'(ROWS));
  assign srow_ok = srow_ext < CHECK_W'(ROWS);

  // Reads and adds share one address path; the row source depends on cmd.
  always_comb begin
    unique case (in_cmd)
      CMD_READ: begin
        rd_addr     = {flip_ext[RW-1:0], col_ext[CW-1:0]};
        rd_in_range = srow_ok && col_ok;
      end
      default: begin
        rd_addr     = {lvl_ext[RW-1:0], col_ext[CW-1:0]};
        rd_in_range = lvl_ok && col_ok;
      end
    endcase
  end

  // A read result can leave the update stage only if the output register
  // is empty or is being drained in this cycle.
  assign s1_advance = !(s1_valid && s1_read && out_valid && !out_ready);
  assign in_ready   = !clearing && s1_advance;
  assign in_accept  = in_valid && in_ready;

  // Read-modify-write of the cell in the update stage.
  assign s1_cell      = fwd_hit ? fwd_data : rd_data;
  assign s1_cell_next = (s1_cell == CELL_MAX) ? s1_cell : s1_cell + HW'(1);
  assign s1_write     = s1_valid && !s1_read && s1_in_range;

  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clear_pointer;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_write;
      mem_waddr = s1_addr;
      mem_wdata = s1_cell_next;
    end
  end

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hit_grid[mem_waddr] <= mem_wdata;
    end
    if (in_accept) begin
      rd_data <= hit_grid[rd_addr];
    end
  end

  // Payload of the update stage and the forwarding capture. A write that
  // commits on the same edge as the read of the same cell is not seen by
  // the memory read, so its value is kept beside the read data.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_read     <= (in_cmd == CMD_READ);
      s1_in_range <= rd_in_range;
      s1_addr     <= rd_addr;
      fwd_hit     <= s1_write && (s1_addr == rd_addr);
      fwd_data    <= s1_cell_next;
    end
  end

  // Control: update stage occupancy and the clearing sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      clearing      <= 1'b1;
      clear_pointer <= '0;
    end else begin
      if (in_accept) begin
        s1_valid <= (in_cmd == CMD_ADD) || (in_cmd == CMD_READ);
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end

      if (clearing) begin
        clear_pointer <= clear_pointer + AW'(1);
        if (&clear_pointer) begin
          clearing <= 1'b0;
        end
      end else if (in_accept && (in_cmd == CMD_CLEAR)) begin
        clearing      <= 1'b1;
        clear_pointer <= '0;
      end
    end
  end

  // Output register for read results.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_read && s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_read && s1_advance) begin
      heat_level <= s1_in_range ? HEAT_W'(s1_cell) : '0;
      draw_pixel <= s1_in_range && (s1_cell != '0);
    end
  end

endmodule

`default_nettype wire
